// File: hw/rtl/cas_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cas_pkg: shared types and constants for cave automaton smoothing
// Sizes, configuration register codes, the result record and the
// neighbourhood rule used by the smoothing datapath.
// ---------------------------------------------------------------------------
package cas_pkg;

  // Frame size limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Column index, row count (holds the flush row) and register widths
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT + 1);
  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 1;

  // Wall count at which a cell keeps its value
  localparam int SPLIT_COUNT = 4;

  // Line buffer: bit 0 previous row, bit 1 row before that
  localparam int LINE_W = 2;

  // Result queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic cell_out;
    logic row_end;
    logic frame_end;
  } result_t;

  // Up to two results caused by one input transaction, in output order
  typedef struct packed {
    logic    first_v;
    result_t first;
    logic    second_v;
    result_t second;
  } push_t;

  // Number of set bits in a three-cell column
  function automatic logic [1:0] ones3(input logic [2:0] v);
    ones3 = 2'(v[0]) + 2'(v[1]) + 2'(v[2]);
  endfunction

  // Columns: bit 0 bottom, bit 1 middle (cell row), bit 2 top
  function automatic logic smooth(input logic [2:0] left, input logic [2:0] mid,
                                  input logic [2:0] right);
    logic [3:0] open_cnt;
    logic [3:0] walls;
    open_cnt = 4'(ones3(left)) + 4'(ones3(right)) + 4'(mid[0]) + 4'(mid[2]);
    walls    = 4'd8 - open_cnt;
    if (walls > 4'(SPLIT_COUNT))      smooth = 1'b0;
    else if (walls < 4'(SPLIT_COUNT)) smooth = 1'b1;
    else                              smooth = mid[1];
  endfunction

endpackage

// File: hw/rtl/cas_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cas_in_if: input cell channel
// Valid/ready channel carrying one grid cell or one flush pad item.
// ---------------------------------------------------------------------------
interface cas_in_if;
  logic valid;
  logic ready;
  logic cell_req;
  logic pad;

  modport source (output valid, output cell_req, output pad, input ready);
  modport sink   (input valid, input cell_req, input pad, output ready);
endinterface

// File: hw/rtl/cas_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cas_out_if: smoothed cell channel
// Valid/ready channel carrying one smoothed cell with row and frame markers.
// ---------------------------------------------------------------------------
interface cas_out_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic row_end;
  logic frame_end;

  modport source (output valid, output cell_out, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input cell_out, input row_end, input frame_end,
                  output ready);
endinterface

// File: hw/rtl/cave_automaton_smoothing_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cave_automaton_smoothing_top: one generation of 4-5 rule cave smoothing
// Streams a binary grid in raster order (0 wall, 1 open) and returns the
// smoothed grid in raster order, one row and one column behind the input.
//
// in_chan: one cell per transaction; after each frame the source sends
//   frame_width pad transactions to flush the last row.
// out_chan: smoothed cells, with row_end on the last cell of each row and
//   frame_end on the last cell of the frame.
// cfg_*: write frame_width (index 0) or frame_height (index 1) while idle;
//   a write restarts the stream position at the top left of a frame.
// Throughput: one input transaction per cycle while the queue has space. The
//   input transaction that ends a row can release two results, so a result queue
//   of four entries absorbs the extra one; one result per cycle leaves on the
//   output side while out_chan.ready is high. With the queue empty a result is
//   on out_chan the cycle after its transaction, the row end result behind it;
//   row 0 releases nothing. The two rows above each column live in a
//   MAX_WIDTH x 2 line buffer RAM, read one transaction ahead with a bypass for same-column rewrites.
// Reset: position, window and queue cleared, frame size 1024 x 1024.
// Stall: when out_chan.ready is low the queue fills and in_chan.ready drops
//   once fewer than two entries are free; nothing is lost.
// ---------------------------------------------------------------------------
module cave_automaton_smoothing_top (
  input  logic                                clk,
  input  logic                                rst_n,
  cas_in_if.sink                              in_chan,
  cas_out_if.source                           out_chan,
  input  logic                                cfg_we,
  input  logic [cas_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cas_pkg::CFG_W-1:0]           cfg_wdata
);

  logic [cas_pkg::CFG_W-1:0]  fw_r, fw_nxt;
  logic [cas_pkg::CFG_W-1:0]  fh_r, fh_nxt;
  logic [cas_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [cas_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [5:0]                 win_r, win_nxt;
  logic                       byp_r;
  logic [cas_pkg::LINE_W-1:0] byp_data_r;

  logic [cas_pkg::CFG_W-1:0]  w_eff, h_eff;
  logic [cas_pkg::COL_W-1:0]  last_col;
  logic [cas_pkg::ROW_W-1:0]  h_row;
  logic                       accept;
  logic                       space;
  logic [cas_pkg::LINE_W-1:0] ram_q, stored, wr_data;
  logic                       bottom, mid, top;
  logic [2:0]                 v, lo, hi;
  logic                       at_last;
  cas_pkg::push_t             push;

  assign accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = space;

  // Effective frame size: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (fw_r == '0)                                      w_eff = cas_pkg::CFG_W'(1);
    else if (fw_r > cas_pkg::CFG_W'(cas_pkg::MAX_WIDTH)) w_eff = cas_pkg::CFG_W'(cas_pkg::MAX_WIDTH);
    else                                                 w_eff = fw_r;
    if (fh_r == '0)                                       h_eff = cas_pkg::CFG_W'(1);
    else if (fh_r > cas_pkg::CFG_W'(cas_pkg::MAX_HEIGHT)) h_eff = cas_pkg::CFG_W'(cas_pkg::MAX_HEIGHT);
    else                                                  h_eff = fh_r;
  end

  assign last_col = cas_pkg::COL_W'(w_eff - cas_pkg::CFG_W'(1));
  assign h_row    = cas_pkg::ROW_W'(h_eff);
  assign at_last  = col_r == last_col;

  // Build the incoming column: bottom from the stream, rows above from RAM
  assign stored = byp_r ? byp_data_r : ram_q;
  assign bottom = (row_r < h_row) && !in_chan.pad && in_chan.cell_req;
  assign mid    = (row_r != '0) && stored[0];
  assign top    = (row_r > cas_pkg::ROW_W'(1)) && stored[1];
  assign v      = {top, mid, bottom};
  assign lo     = (col_r != '0) ? win_r[2:0] : 3'b000;
  assign hi     = (col_r > cas_pkg::COL_W'(1)) ? win_r[5:3] : 3'b000;
  assign wr_data = {mid, bottom};

  // Results released by this transaction
  always_comb begin
    push.first_v            = accept && (row_r != '0) && (col_r != '0);
    push.first.cell_out     = cas_pkg::smooth(hi, lo, v);
    push.first.row_end      = 1'b0;
    push.first.frame_end    = 1'b0;
    push.second_v           = accept && (row_r != '0) && at_last;
    push.second.cell_out    = cas_pkg::smooth(lo, v, 3'b000);
    push.second.row_end     = 1'b1;
    push.second.frame_end   = row_r == h_row;
  end

  // Next stream position, window and configuration
  always_comb begin
    fw_nxt  = fw_r;
    fh_nxt  = fh_r;
    col_nxt = col_r;
    row_nxt = row_r;
    win_nxt = win_r;
    if (cfg_we) begin
      case (cas_pkg::cfg_index_t'(cfg_index))
        cas_pkg::CFG_FRAME_WIDTH:  fw_nxt = cfg_wdata;
        cas_pkg::CFG_FRAME_HEIGHT: fh_nxt = cfg_wdata;
        default: ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
      win_nxt = '0;
    end else if (accept) begin
      if (at_last) begin
        col_nxt = '0;
        win_nxt = '0;
        row_nxt = (row_r >= h_row) ? '0 : row_r + cas_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + cas_pkg::COL_W'(1);
        win_nxt = {lo, v};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= cas_pkg::CFG_W'(cas_pkg::MAX_WIDTH);
      fh_r  <= cas_pkg::CFG_W'(cas_pkg::MAX_HEIGHT);
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
      byp_r <= 1'b0;
    end else begin
      fw_r  <= fw_nxt;
      fh_r  <= fh_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      win_r <= win_nxt;
      byp_r <= accept && (col_r == col_nxt);
    end
  end

  // Hold the value just written when the next read hits the same column
  always_ff @(posedge clk) begin
    byp_data_r <= wr_data;
  end

  // Line buffer: read ahead at the next column, write back the current one
  cas_ram #(
    .WIDTH (cas_pkg::LINE_W),
    .DEPTH (cas_pkg::MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_r),
    .wr_data (wr_data),
    .rd_addr (col_nxt),
    .rd_data (ram_q)
  );

  cas_result_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space    (space),
    .out_chan (out_chan)
  );

endmodule

// File: hw/rtl/cas_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cas_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data. A read at the
// address being written in the same cycle returns the old contents.
// ---------------------------------------------------------------------------
module cas_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/cas_result_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cas_result_queue: result output queue
// Small register queue that takes up to two results per cycle and hands one
// per cycle to the output channel while out_chan.ready is high. Space for two
// is reported so that the input side never has to look at the output ready.
// ---------------------------------------------------------------------------
module cas_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  cas_pkg::push_t      push,
  output logic                space,
  cas_out_if.source           out_chan
);

  cas_pkg::result_t             entry_r [cas_pkg::QUEUE_DEPTH];
  logic [cas_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [cas_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [cas_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                         pop;
  logic [cas_pkg::QPTR_W-1:0]   second_ptr;
  cas_pkg::result_t             head;

  assign pop        = out_chan.valid && out_chan.ready;
  assign second_ptr = wr_ptr_r + cas_pkg::QPTR_W'(push.first_v);
  assign space      = count_r <= cas_pkg::QCNT_W'(cas_pkg::QUEUE_DEPTH - 2);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + cas_pkg::QPTR_W'(push.first_v)
                          + cas_pkg::QPTR_W'(push.second_v);
    rd_ptr_nxt = rd_ptr_r + cas_pkg::QPTR_W'(pop);
    count_nxt  = count_r + cas_pkg::QCNT_W'(push.first_v)
                         + cas_pkg::QCNT_W'(push.second_v)
                         - cas_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store incoming results in order
  always_ff @(posedge clk) begin
    if (push.first_v) begin
      entry_r[wr_ptr_r] <= push.first;
    end
    if (push.second_v) begin
      entry_r[second_ptr] <= push.second;
    end
  end

  // Present the head entry
  assign head               = entry_r[rd_ptr_r];
  assign out_chan.valid     = count_r != '0;
  assign out_chan.cell_out  = head.cell_out;
  assign out_chan.row_end   = head.row_end;
  assign out_chan.frame_end = head.frame_end;

endmodule

// File: hw/rtl/cas_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cas_checker: port-level checks for cave automaton smoothing
// Watches the top level's channels over time and reports violations.
// ---------------------------------------------------------------------------
module cas_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_cell,
  input logic out_row_end,
  input logic out_frame_end
);

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell)
      && $stable(out_row_end) && $stable(out_frame_end))
    else $error("stalled result changed");

  // The frame closes only at a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  // Results appear only after an input transaction
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without a preceding input transaction");

endmodule

bind cave_automaton_smoothing_top cas_checker u_cas_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_cell      (out_chan.cell_out),
  .out_row_end   (out_chan.row_end),
  .out_frame_end (out_chan.frame_end)
);
